FILE: rtl/tsp_pkg.sv
// Types and constants shared by the TLV stream parser.
`timescale 1ns / 1ps

package tsp_pkg;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_MAX_BYTES   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DESCEND_CONTAINERS = 4'd1;

   localparam logic [3:0] NUMBER_MAX_BYTES_RESET   = 4'd8;
   localparam logic       DESCEND_CONTAINERS_RESET = 1'b1;

   localparam logic       EV_HEADER   = 1'b0;
   localparam logic       EV_PAYLOAD  = 1'b1;
   localparam logic [1:0] T_OBJ_INST  = 2'd0;
   localparam logic [1:0] T_RES_INST  = 2'd1;
   localparam logic [1:0] T_MULTI_RES = 2'd2;
   localparam logic [1:0] T_RESOURCE  = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic               event_res;
      logic [1:0]         tlv_kind;
      logic [15:0]        tlv_ident;
      logic [23:0]        tlv_length;
      logic [7:0]         payload_byte;
      logic               payload_last;
      logic signed [63:0] number_value;
      logic               number_ok;
   } rsp_type;

endpackage

FILE: rtl/tlv_stream_parser_core.sv
// TLV stream parser: one stream byte in per transfer, header and payload events out.
// Each result is registered and valid in the cycle after the byte that causes it is accepted.
// One byte per cycle unless a result stalls; the register frees in the cycle it is taken.
// Header and payload decode runs as one pass from the input port into the result register.
// Synchronous reset: parser expects a type byte, held fields and counters clear,
// number_max_bytes returns to 8 and descend_containers to 1.
`timescale 1ns / 1ps

module tlv_stream_parser_core
   import tsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam logic [1:0] PH_TYPE    = 2'd0;
   localparam logic [1:0] PH_IDENT   = 2'd1;
   localparam logic [1:0] PH_LENGTH  = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   logic [3:0]  max_bytes_ff;
   logic        descend_ff;

   logic [1:0]  phase_ff,       phase_in;
   logic [1:0]  type_ff,        type_in;
   logic [15:0] ident_ff,       ident_in;
   logic [1:0]  ident_left_ff,  ident_left_in;
   logic [1:0]  len_left_ff,    len_left_in;
   logic [23:0] length_ff,      length_in;
   logic [23:0] pay_left_ff,    pay_left_in;
   logic [63:0] accum_ff,       accum_in;

   logic        rsp_valid_ff,   rsp_valid_in;
   rsp_type     rsp_ff,         rsp_in;

   logic        accept;
   logic        rsp_set;
   logic        hdr_done;
   logic        sized;
   logic        num_ok;
   logic [63:0] ext_value;
   logic [7:0]  b;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign b         = req_data.data_byte;

   // Number check and sign extension of the completed payload word.
   always_comb begin
      sized = (length_ff == 24'd1) || (length_ff == 24'd2) ||
              (length_ff == 24'd4) || (length_ff == 24'd8);
      num_ok = sized && (length_ff <= {20'd0, max_bytes_ff});
      case (length_ff[3:0])
         4'd1:    ext_value = {{56{accum_in[7]}},  accum_in[7:0]};
         4'd2:    ext_value = {{48{accum_in[15]}}, accum_in[15:0]};
         4'd4:    ext_value = {{32{accum_in[31]}}, accum_in[31:0]};
         default: ext_value = accum_in;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      type_in       = type_ff;
      ident_in      = ident_ff;
      ident_left_in = ident_left_ff;
      len_left_in   = len_left_ff;
      length_in     = length_ff;
      pay_left_in   = pay_left_ff;
      accum_in      = accum_ff;
      hdr_done      = 1'b0;
      rsp_set       = 1'b0;
      rsp_in        = rsp_ff;

      if (accept) begin
         if (req_data.frame_start || phase_ff == PH_TYPE) begin
            type_in       = b[7:6];
            ident_left_in = b[5] ? 2'd2 : 2'd1;
            len_left_in   = b[4:3];
            length_in     = (b[4:3] == 2'd0) ? {21'd0, b[2:0]} : 24'd0;
            ident_in      = 16'd0;
            pay_left_in   = 24'd0;
            accum_in      = 64'd0;
            phase_in      = PH_IDENT;
         end else if (phase_ff == PH_IDENT) begin
            ident_in      = {ident_ff[7:0], b};
            ident_left_in = ident_left_ff - 2'd1;
            if (ident_left_in == 2'd0) begin
               if (len_left_ff == 2'd0) begin
                  hdr_done = 1'b1;
               end else begin
                  phase_in = PH_LENGTH;
               end
            end
         end else if (phase_ff == PH_LENGTH) begin
            length_in   = {length_ff[15:0], b};
            len_left_in = len_left_ff - 2'd1;
            if (len_left_in == 2'd0) begin
               hdr_done = 1'b1;
            end
         end else begin
            accum_in    = {accum_ff[55:0], b};
            pay_left_in = pay_left_ff - 24'd1;
            rsp_set     = 1'b1;
            rsp_in.event_res    = EV_PAYLOAD;
            rsp_in.tlv_kind     = type_ff;
            rsp_in.tlv_ident    = ident_ff;
            rsp_in.tlv_length   = length_ff;
            rsp_in.payload_byte = b;
            if (pay_left_in != 24'd0) begin
               rsp_in.payload_last = 1'b0;
               rsp_in.number_value = 64'sd0;
               rsp_in.number_ok    = 1'b0;
            end else begin
               rsp_in.payload_last = 1'b1;
               rsp_in.number_value = num_ok ? $signed(ext_value) : 64'sd0;
               rsp_in.number_ok    = num_ok;
               phase_in            = PH_TYPE;
            end
         end

         if (hdr_done) begin
            rsp_set             = 1'b1;
            rsp_in.event_res    = EV_HEADER;
            rsp_in.tlv_kind     = type_in;
            rsp_in.tlv_ident    = ident_in;
            rsp_in.tlv_length   = length_in;
            rsp_in.payload_byte = 8'd0;
            rsp_in.payload_last = 1'b0;
            rsp_in.number_value = 64'sd0;
            rsp_in.number_ok    = 1'b0;
            pay_left_in         = length_in;
            accum_in            = 64'd0;
            // With descend_containers set, containers descend straight into their child headers.
            if (length_in == 24'd0 ||
                (descend_ff && (type_in == T_OBJ_INST || type_in == T_MULTI_RES))) begin
               phase_in = PH_TYPE;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
      end

      if (rsp_set) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TYPE;
         type_ff       <= 2'd0;
         ident_ff      <= 16'd0;
         ident_left_ff <= 2'd0;
         len_left_ff   <= 2'd0;
         length_ff     <= 24'd0;
         pay_left_ff   <= 24'd0;
         accum_ff      <= 64'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         type_ff       <= type_in;
         ident_ff      <= ident_in;
         ident_left_ff <= ident_left_in;
         len_left_ff   <= len_left_in;
         length_ff     <= length_in;
         pay_left_ff   <= pay_left_in;
         accum_ff      <= accum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold the result until it is taken.
   always_ff @(posedge clock) begin
      if (rsp_set) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= NUMBER_MAX_BYTES_RESET;
         descend_ff   <= DESCEND_CONTAINERS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUMBER_MAX_BYTES:   max_bytes_ff <= csr_data;
            CSR_DESCEND_CONTAINERS: descend_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

endmodule

FILE: dv/tlv_stream_parser_core_tb.sv
// Self-checking testbench for the TLV stream parser core: directed table plus random streams.
`timescale 1ns / 1ps

module tlv_stream_parser_core_tb;
   import tsp_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 4'hF;
   localparam int HOLD_CYCLES = 400;

   typedef enum logic [1:0] {
      SEEK_TYPE, TAKE_IDENT, TAKE_LENGTH, TAKE_PAYLOAD
   } parse_phase_type;

   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type rsp;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // typed-in expectation riding along with the byte on offer
   bit      cur_fixed = 1'b0;
   rsp_type cur_fixed_rsp = '0;

   rsp_type     pending_events[$];
   dir_row_type dir_tab[$];
   int          error_count = 0;
   int          bytes_sent = 0;
   int          snd_idle_pct = 0;
   int          rcv_idle_pct = 0;
   int          hold_asked = 0;

   // predictor state and its copy of the registers
   parse_phase_type ph;
   logic [1:0]   h_type;
   logic [15:0]  h_ident;
   logic [1:0]   id_left;
   logic [1:0]   len_left;
   logic [23:0]  h_len;
   logic [23:0]  pay_left;
   logic [63:0]  acc;
   logic [3:0]   cfg_max;
   logic         cfg_descend;

   tlv_stream_parser_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   function automatic void close_header(output bit got, output rsp_type res);
      res = '0;
      res.event_res = EV_HEADER;
      res.tlv_kind = h_type;
      res.tlv_ident = h_ident;
      res.tlv_length = h_len;
      got = 1'b1;
      pay_left = h_len;
      acc = '0;
      if (h_len == 0)
         ph = SEEK_TYPE;
      else if (cfg_descend && (h_type == T_OBJ_INST || h_type == T_MULTI_RES))
         ph = SEEK_TYPE;
      else
         ph = TAKE_PAYLOAD;
   endfunction

   function automatic void parse_byte(input req_type r, output bit got, output rsp_type res);
      logic [1:0]  lt;
      int unsigned n;
      int unsigned sh;
      logic [63:0] v;
      got = 1'b0;
      res = '0;
      if (r.frame_start || ph == SEEK_TYPE) begin
         lt = r.data_byte[4:3];
         h_type = r.data_byte[7:6];
         id_left = r.data_byte[5] ? 2'd2 : 2'd1;
         len_left = lt;
         h_len = (lt == 0) ? {21'd0, r.data_byte[2:0]} : 24'd0;
         h_ident = '0;
         pay_left = '0;
         acc = '0;
         ph = TAKE_IDENT;
      end else if (ph == TAKE_IDENT) begin
         h_ident = {h_ident[7:0], r.data_byte};
         id_left = id_left - 2'd1;
         if (id_left == 0) begin
            if (len_left == 0)
               close_header(got, res);
            else
               ph = TAKE_LENGTH;
         end
      end else if (ph == TAKE_LENGTH) begin
         h_len = {h_len[15:0], r.data_byte};
         len_left = len_left - 2'd1;
         if (len_left == 0)
            close_header(got, res);
      end else begin
         acc = {acc[55:0], r.data_byte};
         pay_left = pay_left - 24'd1;
         got = 1'b1;
         res.event_res = EV_PAYLOAD;
         res.tlv_kind = h_type;
         res.tlv_ident = h_ident;
         res.tlv_length = h_len;
         res.payload_byte = r.data_byte;
         if (pay_left == 0) begin
            res.payload_last = 1'b1;
            n = {8'd0, h_len};
            if ((n == 1 || n == 2 || n == 4 || n == 8) && n <= cfg_max) begin
               // sign-extend from the top of the n-byte value
               sh = 64 - 8 * n;
               v = acc << sh;
               res.number_value = $signed(v) >>> sh;
               res.number_ok = 1'b1;
            end
            ph = SEEK_TYPE;
         end
      end
   endfunction

   task automatic flag_field(input string name, input logic [63:0] want, input logic [63:0] got);
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin : monitor
      rsp_type pred;
      rsp_type want;
      bit      got;
      if (reset) begin
         ph = SEEK_TYPE;
         h_type = '0;
         h_ident = '0;
         id_left = '0;
         len_left = '0;
         h_len = '0;
         pay_left = '0;
         acc = '0;
         cfg_max = NUMBER_MAX_BYTES_RESET;
         cfg_descend = DESCEND_CONTAINERS_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NUMBER_MAX_BYTES)
               cfg_max = csr_data;
            else if (csr_index == CSR_DESCEND_CONTAINERS)
               cfg_descend = csr_data[0];
         end
         if (req_valid && req_ready) begin
            parse_byte(req_data, got, pred);
            if (got)
               pending_events.push_back(cur_fixed ? cur_fixed_rsp : pred);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               $display("%0t ns: unexpected event, expected none, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               want = pending_events.pop_front();
               if (rsp_data.event_res !== want.event_res)
                  flag_field("event_res", 64'(want.event_res), 64'(rsp_data.event_res));
               if (rsp_data.tlv_kind !== want.tlv_kind)
                  flag_field("tlv_kind", 64'(want.tlv_kind), 64'(rsp_data.tlv_kind));
               if (rsp_data.tlv_ident !== want.tlv_ident)
                  flag_field("tlv_ident", 64'(want.tlv_ident), 64'(rsp_data.tlv_ident));
               if (rsp_data.tlv_length !== want.tlv_length)
                  flag_field("tlv_length", 64'(want.tlv_length), 64'(rsp_data.tlv_length));
               if (rsp_data.payload_byte !== want.payload_byte)
                  flag_field("payload_byte", 64'(want.payload_byte),
                             64'(rsp_data.payload_byte));
               if (rsp_data.payload_last !== want.payload_last)
                  flag_field("payload_last", 64'(want.payload_last),
                             64'(rsp_data.payload_last));
               if (rsp_data.number_value !== want.number_value)
                  flag_field("number_value", want.number_value, rsp_data.number_value);
               if (rsp_data.number_ok !== want.number_ok)
                  flag_field("number_ok", 64'(want.number_ok), 64'(rsp_data.number_ok));
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin : receiver
      int hold_taken;
      int left;
      hold_taken = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_taken) begin
            hold_taken++;
            left = HOLD_CYCLES;
         end
         if (left != 0) begin
            left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fs, input bit fixed,
                            input rsp_type fr);
      req_type r;
      r.data_byte = b;
      r.frame_start = fs;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      cur_fixed <= fixed;
      cur_fixed_rsp <= fr;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // stop offering and let every expected event come out
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < 5000 && pending_events.size() != 0; k++)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic rsp_type hdr_exp(input logic [1:0] typ, input logic [15:0] id,
                                       input logic [23:0] len);
      rsp_type r;
      r = '0;
      r.event_res = EV_HEADER;
      r.tlv_kind = typ;
      r.tlv_ident = id;
      r.tlv_length = len;
      return r;
   endfunction

   function automatic rsp_type last_exp(input logic [1:0] typ, input logic [15:0] id,
                                        input logic [23:0] len, input logic [7:0] pb,
                                        input logic [63:0] val);
      rsp_type r;
      r = hdr_exp(typ, id, len);
      r.event_res = EV_PAYLOAD;
      r.payload_byte = pb;
      r.payload_last = 1'b1;
      r.number_value = val;
      r.number_ok = 1'b1;
      return r;
   endfunction

   function automatic void add_row(input logic [7:0] b, input logic fs, input bit fixed,
                                   input rsp_type r);
      dir_row_type row;
      row.req.data_byte = b;
      row.req.frame_start = fs;
      row.fixed = fixed;
      row.rsp = r;
      dir_tab.push_back(row);
   endfunction

   // one well-formed element, optionally cut short after a random prefix
   task automatic send_element(input logic fs, input bit broken);
      logic [7:0]  seq[$];
      logic [1:0]  typ;
      logic [1:0]  lt;
      logic        wide;
      int unsigned len;
      int unsigned keep;
      typ = 2'($urandom_range(3));
      wide = 1'($urandom_range(1));
      case ($urandom_range(19))
         0: len = $urandom_range(40, 10);
         1, 2: len = 0;
         default: len = $urandom_range(9, 1);
      endcase
      if (len <= 7)
         lt = 2'($urandom_range(3));
      else
         lt = 2'($urandom_range(3, 1));
      seq.push_back({typ, wide, lt, (lt == 0) ? len[2:0] : 3'($urandom_range(7))});
      seq.push_back(8'($urandom));
      if (wide)
         seq.push_back(8'($urandom));
      for (int k = lt - 1; k >= 0; k--)
         seq.push_back(8'(len >> (8 * k)));
      if (!(cfg_descend && (typ == T_OBJ_INST || typ == T_MULTI_RES) && len != 0)) begin
         for (int k = 0; k < len; k++)
            seq.push_back(8'($urandom));
      end
      keep = seq.size();
      if (broken && keep > 1)
         keep = $urandom_range(keep - 1, 1);
      for (int k = 0; k < keep; k++)
         send_byte(seq[k], (k == 0) ? fs : 1'b0, 1'b0, '0);
   endtask

   task automatic run_stream(input int goal);
      int  stop_at;
      bit  need_fs;
      int  pick;
      stop_at = bytes_sent + goal;
      need_fs = 1'b1;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // noise: random bytes, random restarts
            repeat ($urandom_range(4, 1))
               send_byte(8'($urandom), 1'($urandom_range(1)), 1'b0, '0);
            need_fs = 1'b1;
         end else if (pick < 18) begin
            send_element(need_fs | 1'($urandom_range(1)), 1'b1);
            need_fs = 1'b1;
         end else begin
            send_element(need_fs | ($urandom_range(3) == 0), 1'b0);
            need_fs = 1'b0;
         end
      end
   endtask

   initial begin : watchdog
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [3:0] max_set[6];
      logic       desc_set[6];
      max_set = '{4'd15, 4'd0, 4'd1, 4'd4, 4'd2, 4'd8};
      desc_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

      // resource, inline length 1, all-ones payload
      add_row(8'hC1, 1'b1, 1'b0, '0);
      add_row(8'h05, 1'b0, 1'b1, hdr_exp(T_RESOURCE, 16'h0005, 24'd1));
      add_row(8'hFF, 1'b0, 1'b1, last_exp(T_RESOURCE, 16'h0005, 24'd1, 8'hFF, '1));
      // two-byte identifier, three length bytes, most negative 8-byte value
      add_row(8'hF8, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h08, 1'b0, 1'b1, hdr_exp(T_RESOURCE, 16'hFFFF, 24'd8));
      add_row(8'h80, 1'b0, 1'b0, '0);
      repeat (6) add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b1,
              last_exp(T_RESOURCE, 16'hFFFF, 24'd8, 8'h00, 64'h8000_0000_0000_0000));
      // empty payload
      add_row(8'h40, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b1, hdr_exp(T_RES_INST, 16'h0000, 24'd0));
      // container: next byte is a child header
      add_row(8'h02, 1'b0, 1'b0, '0);
      add_row(8'h07, 1'b0, 1'b1, hdr_exp(T_OBJ_INST, 16'h0007, 24'd2));
      // payload cut off by a forced type byte
      add_row(8'hC2, 1'b0, 1'b0, '0);
      add_row(8'h01, 1'b0, 1'b1, hdr_exp(T_RESOURCE, 16'h0001, 24'd2));
      add_row(8'h12, 1'b0, 1'b0, '0);
      add_row(8'h60, 1'b1, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'hAB, 1'b0, 1'b1, hdr_exp(T_RES_INST, 16'h00AB, 24'd0));

      snd_idle_pct = 7;
      rcv_idle_pct = 73;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         send_byte(dir_tab[i].req.data_byte, dir_tab[i].req.frame_start,
                   dir_tab[i].fixed, dir_tab[i].rsp);
      settle();
      write_csr(CSR_UNUSED_INDEX, 4'h5);

      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_NUMBER_MAX_BYTES, max_set[p]);
         write_csr(CSR_DESCEND_CONTAINERS, {3'($urandom), desc_set[p]});
         if (p == 2) begin
            snd_idle_pct = 73;
            rcv_idle_pct = 7;
         end else if (p == 4) begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
            hold_asked++;
         end
         if (p == 3) begin
            // pause mid-stream until the block has drained
            run_stream(46);
            settle();
            run_stream(46);
         end else begin
            run_stream(92);
         end
         settle();
      end

      if (pending_events.size() != 0) begin
         $display("%0t ns: %0d events expected, none received", $time, pending_events.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
